// ----- sv/assert_macros.svh -----
// Assertion macros shared by the RTL that checks itself.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/lgmr_pkg.sv -----
// Package for the int8 table-gated multiply and requantize block.
// Holds field widths, function codes, register addresses and saturation limits.
`timescale 1ns / 1ps
`default_nettype none

package lgmr_pkg;

  localparam int TableDepth = 256;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int ByteW      = 8;
  localparam int ProdW      = 2 * ByteW;
  localparam int ScaleW     = 32;
  localparam int ShiftW     = 6;
  localparam int WideW      = ProdW + ScaleW;
  localparam int MagW       = 46;
  localparam int SumW       = MagW + 1;
  localparam int AddrW      = 3;
  localparam int DataW      = 32;

  // Function codes of an input beat.
  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_COMPUTE = 1'b1;

  // Register indexes, decoded from paddr[2].
  localparam logic REG_SCALE_MULT = 1'b0;
  localparam logic REG_SHIFT_AMT  = 1'b1;

  localparam logic [ScaleW-1:0] SCALE_MULT_RST = 32'd1;
  localparam logic [ShiftW-1:0] SHIFT_AMT_RST  = 6'd0;
  localparam logic [ShiftW-1:0] SHIFT_LIMIT    = 6'd46;

  localparam logic [ByteW-1:0] IDX_FLIP = 8'h80;
  localparam logic [ByteW-1:0] SAT_MAX  = 8'h7F;
  localparam logic [ByteW-1:0] SAT_MIN  = 8'h80;

  typedef logic signed [ByteW-1:0] sbyte_t;

endpackage

`default_nettype wire

// ----- sv/int8_lut_gate_multiply_requant.sv -----
// Top level of the int8 table-gated multiply and requantize block.
// Depends on lgmr_pkg and assert_macros.svh.
//
// Input channel (in_*): one beat per cycle while in_stall is low. func=0 writes
// table_word into the 256-entry activation table at table_index and gives no
// result. func=1 looks up the table at gate+128, multiplies by up_value and
// scale_multiplier, shifts right by the configured shift amount rounding half
// away from zero, and saturates to int8.
// Result channel (out_*): gated_out and last_out, one beat per compute item,
// in input order.
// Pipeline: a compute beat accepted at the input passes through the stage
// registers s1 to s5 in order and shows on out_valid from stage five. Throughput:
// one beat per cycle while out_stall is low, set by the five-stage pipeline
// (table read, 8x8 multiply, 16x32 multiply, magnitude, round and saturate).
// Stall: each stage holds while the next is full and stalled; empty stages
// still fill, so in_stall rises only once stage one is occupied and blocked.
// Reset clears all stage valids, loads scale_multiplier=1 and a zero shift.
// The table is not cleared; read an entry only after writing it.
// The user must write configuration (APB, pready tied high) only while the block is idle; it is not enforced.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module int8_lut_gate_multiply_requant (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_func,
  input  lgmr_pkg::sbyte_t                    in_gate_value,
  input  lgmr_pkg::sbyte_t                    in_up_value,
  input  logic [lgmr_pkg::IdxW-1:0]           in_table_index,
  input  lgmr_pkg::sbyte_t                    in_table_word,
  input  logic                                in_last_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output lgmr_pkg::sbyte_t                    out_gated_out,
  output logic                                out_last_out,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lgmr_pkg::AddrW-1:0]          paddr,
  input  logic [lgmr_pkg::DataW-1:0]          pwdata,
  output logic [lgmr_pkg::DataW-1:0]          prdata,
  output logic                                pready
);
  import lgmr_pkg::*;

  // Configuration registers
  logic signed [ScaleW-1:0] scale_mult_r;
  logic [ShiftW-1:0]        shift_amt_r;
  logic                     cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_mult_r <= SCALE_MULT_RST;
      shift_amt_r  <= SHIFT_AMT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_SCALE_MULT: scale_mult_r <= pwdata;
        REG_SHIFT_AMT:  shift_amt_r  <= pwdata[ShiftW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SCALE_MULT: prdata = scale_mult_r;
      REG_SHIFT_AMT:  prdata = {{(DataW-ShiftW){1'b0}}, shift_amt_r};
      default:        prdata = '0;
    endcase
  end

  // Stage valids and advance enables
  logic s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r, s5_valid_r;
  logic en1, en2, en3, en4, en5;
  logic in_acc;

  assign en5      = !s5_valid_r || !out_stall;
  assign en4      = !s4_valid_r || en5;
  assign en3      = !s3_valid_r || en4;
  assign en2      = !s2_valid_r || en3;
  assign en1      = !s1_valid_r || en2;
  assign in_stall = !en1;
  assign in_acc   = in_valid && en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
    end else begin
      if (en1) s1_valid_r <= in_acc && (in_func == FUNC_COMPUTE);
      if (en2) s2_valid_r <= s1_valid_r;
      if (en3) s3_valid_r <= s2_valid_r;
      if (en4) s4_valid_r <= s3_valid_r;
      if (en5) s5_valid_r <= s4_valid_r;
    end
  end

  // Stage 1: activation table write or registered read
  logic [ByteW-1:0] act_mem [TableDepth];
  logic [IdxW-1:0]  rd_idx;
  sbyte_t           s1_act_r;
  sbyte_t           s1_up_r;
  logic             s1_last_r;

  assign rd_idx = IdxW'(in_gate_value ^ IDX_FLIP);

  always_ff @(posedge clk) begin
    if (in_acc && (in_func == FUNC_LOAD)) begin
      act_mem[in_table_index] <= in_table_word;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_act_r  <= act_mem[rd_idx];
      s1_up_r   <= in_up_value;
      s1_last_r <= in_last_in;
    end
  end

  // Stage 2: table value times up byte
  logic signed [ProdW-1:0] s2_prod_r;
  logic                    s2_last_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_prod_r <= s1_act_r * s1_up_r;
      s2_last_r <= s1_last_r;
    end
  end

  // Stage 3: scale multiply
  logic signed [WideW-1:0] s3_wide_r;
  logic                    s3_last_r;

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_wide_r <= WideW'(s2_prod_r) * WideW'(scale_mult_r);
      s3_last_r <= s2_last_r;
    end
  end

  // Stage 4: sign and magnitude (magnitude stays below 2^46)
  logic [WideW-1:0] s3_abs;
  logic [MagW-1:0]  s4_mag_r;
  logic             s4_neg_r;
  logic             s4_last_r;

  assign s3_abs = s3_wide_r[WideW-1] ? (~s3_wide_r + 1'b1) : s3_wide_r;

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_mag_r  <= s3_abs[MagW-1:0];
      s4_neg_r  <= s3_wide_r[WideW-1];
      s4_last_r <= s3_last_r;
    end
  end

  // Stage 5: round half away from zero, shift, saturate
  logic [SumW-1:0]  half;
  logic [SumW-1:0]  rsum;
  logic [SumW-1:0]  qmag;
  logic             big_shift;
  logic [ByteW-1:0] sat;
  sbyte_t           s5_res_r;
  logic             s5_last_r;

  always_comb begin
    big_shift = shift_amt_r > SHIFT_LIMIT;
    if (shift_amt_r == '0 || big_shift) begin
      half = '0;
    end else begin
      half = SumW'(1) << (shift_amt_r - 1'b1);
    end
    rsum = {1'b0, s4_mag_r} + half;
    // every magnitude rounds to zero once the shift passes the limit
    qmag = big_shift ? '0 : (rsum >> shift_amt_r);
    if (s4_neg_r) begin
      sat = (qmag > SumW'(SAT_MIN)) || (qmag == SumW'(SAT_MIN)) ? SAT_MIN
                                                                 : -qmag[ByteW-1:0];
    end else begin
      sat = (qmag > SumW'(SAT_MAX)) ? SAT_MAX : qmag[ByteW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      s5_res_r  <= sat;
      s5_last_r <= s4_last_r;
    end
  end

  assign out_valid     = s5_valid_r;
  assign out_gated_out = s5_res_r;
  assign out_last_out  = s5_last_r;

  // Checks
  `ASSERT_ALWAYS(a_stall_needs_s1, !in_stall || s1_valid_r,
                 "input stalled while stage one is empty")
  `ASSERT_NEXT(a_load_no_result, in_acc && (in_func == FUNC_LOAD), !s1_valid_r,
               "table load beat entered the compute pipeline")
  `ASSERT_NEXT(a_s4_hold, s4_valid_r && !en4, s4_valid_r && $stable(s4_mag_r),
               "stage four lost or changed a held beat")

endmodule

`default_nettype wire
